### hdl/tse_pkg.sv
// Shared types and constants for the Taylor series sine evaluator.
// Holds field widths, fixed-point constants, register codes and the lane struct.
// No dependencies.
package tse_pkg;

  localparam int ANGLE_W             = 32;
  localparam int SINE_W              = 32;
  localparam int WORD_W              = 64;
  localparam int PROD_W              = 2 * WORD_W;
  localparam int WORK_FRAC           = 56;
  localparam int OUT_FRAC            = 29;
  localparam int DIV_W               = 10;

  localparam int DEF_MAX_TERMS       = 12;
  localparam int DEF_ANGLE_FRAC_BITS = 24;

  localparam int TERM_COUNT_W        = 4;
  localparam int TERM_N_W            = 5;
  localparam logic [TERM_COUNT_W-1:0] TERM_COUNT_RESET = 4'd10;

  localparam int APB_ADDR_W          = 3;
  localparam int APB_DATA_W          = 32;
  localparam int REG_IDX_LSB         = 2;
  localparam int REG_IDX_W           = APB_ADDR_W - REG_IDX_LSB;
  localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT = 1'b0;

  localparam logic [WORD_W-1:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [WORD_W-1:0] PI_Q56     = 64'h03243F6A8885A308;
  localparam logic [WORD_W-1:0] TWO_PI_Q56 = 64'h06487ED5110B4611;

  localparam logic signed [SINE_W-1:0] SINE_BOUND = 32'sh6487ED52;

  typedef struct packed {
    logic                     valid;
    logic                     neg_x;
    logic [WORD_W-1:0]        x2;
    logic [WORD_W-1:0]        term;
    logic signed [WORD_W-1:0] sum;
  } tse_lane_t;

endpackage

### hdl/tse_if.sv
// Valid/ready channel interfaces for the angle input and the sine output.
// Depends on tse_pkg for the payload widths.
interface tse_angle_if;
  import tse_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface tse_sine_if;
  import tse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SINE_W-1:0] sine_value;

  modport source (output valid, output sine_value, input ready);
  modport sink (input valid, input sine_value, output ready);
endinterface

### hdl/tse_wide_mul.sv
// Two-stage 64 by 64 bit unsigned multiplier built from four 32 by 32 partial products.
// Depends on tse_pkg for the word widths.
module tse_wide_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tse_pkg::WORD_W-1:0]   a,
  input  logic [tse_pkg::WORD_W-1:0]   b,
  output logic [tse_pkg::PROD_W-1:0]   prod
);
  import tse_pkg::*;

  localparam int HALF = WORD_W / 2;

  logic [WORD_W-1:0] pp_ll;
  logic [WORD_W-1:0] pp_lh;
  logic [WORD_W-1:0] pp_hl;
  logic [WORD_W-1:0] pp_hh;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a[HALF-1:0] * b[HALF-1:0];
      pp_lh <= a[HALF-1:0] * b[WORD_W-1:HALF];
      pp_hl <= a[WORD_W-1:HALF] * b[HALF-1:0];
      pp_hh <= a[WORD_W-1:HALF] * b[WORD_W-1:HALF];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {pp_hh, pp_ll}
            + {{HALF{1'b0}}, pp_lh, {HALF{1'b0}}}
            + {{HALF{1'b0}}, pp_hl, {HALF{1'b0}}};
    end
  end

endmodule

### hdl/tse_reduce.sv
// Angle reduction into [-pi, pi) by a pipelined restoring remainder, then the square of |x|.
// Depends on tse_pkg and tse_wide_mul; emits the first lane of the series pipeline.
module tse_reduce #(
  parameter int ANGLE_FRAC_BITS = tse_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [tse_pkg::ANGLE_W-1:0] angle,
  input  logic [tse_pkg::TERM_N_W-1:0]       n_terms,
  output tse_pkg::tse_lane_t                 lane
);
  import tse_pkg::*;

  // One quotient bit per stage; the quotient of the largest magnitude fits in QBITS bits.
  localparam int QBITS = 29 - ANGLE_FRAC_BITS;
  localparam logic [WORD_W-1:0] MOD_K = TWO_PI_Q60 >> (28 - ANGLE_FRAC_BITS);
  localparam int SHIFT = ANGLE_FRAC_BITS + ANGLE_W - WORK_FRAC;

  logic [ANGLE_W-1:0] mag;
  logic [WORD_W-1:0]  rem [QBITS+1];
  logic [QBITS:0]     rv;
  logic [QBITS:0]     rneg;

  logic [WORD_W-1:0]  wrapped;
  logic [WORD_W-1:0]  r56;
  logic [WORD_W-1:0]  r56_q;
  logic               negx_next;
  logic [WORD_W-1:0]  ax_next;
  logic [WORD_W-1:0]  ax_q;
  logic               negx_q;
  logic [WORD_W-1:0]  ax_d [2];
  logic [1:0]         nx_d;
  logic [3:0]         vw;
  logic [PROD_W-1:0]  sq;

  logic               out_vld;
  logic               out_negx;
  logic [WORD_W-1:0]  out_x2;
  logic [WORD_W-1:0]  out_term;
  logic signed [WORD_W-1:0] out_sum;

  assign mag = angle[ANGLE_W-1] ? ANGLE_W'(~angle + 1'b1) : ANGLE_W'(angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      rv      <= '0;
      vw      <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      rv      <= {rv[QBITS-1:0], in_valid};
      vw      <= {vw[2:0], rv[QBITS]};
      out_vld <= vw[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {mag, {(WORD_W-ANGLE_W){1'b0}}};
      rneg   <= {rneg[QBITS-1:0], angle[ANGLE_W-1]};
      for (int k = 0; k < QBITS; k++) begin
        if (rem[k] >= (MOD_K << (QBITS - 1 - k))) begin
          rem[k+1] <= rem[k] - (MOD_K << (QBITS - 1 - k));
        end else begin
          rem[k+1] <= rem[k];
        end
      end
    end
  end

  // A negative angle with a nonzero remainder folds back to 2pi minus the remainder.
  assign wrapped = (rneg[QBITS] && (rem[QBITS] != '0)) ? MOD_K - rem[QBITS] : rem[QBITS];

  if (SHIFT >= 0) begin : g_shr
    assign r56 = wrapped >> SHIFT;
  end else begin : g_shl
    assign r56 = wrapped << (-SHIFT);
  end

  always_comb begin
    negx_next = (r56_q >= PI_Q56);
    if (!negx_next) begin
      ax_next = r56_q;
    end else if (r56_q < TWO_PI_Q56) begin
      ax_next = TWO_PI_Q56 - r56_q;
    end else begin
      ax_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r56_q   <= r56;
      ax_q    <= ax_next;
      negx_q  <= negx_next;
      ax_d[0] <= ax_q;
      ax_d[1] <= ax_d[0];
      nx_d    <= {nx_d[0], negx_q};
    end
  end

  tse_wide_mul u_square (
    .clk  (clk),
    .en   (en),
    .a    (ax_q),
    .b    (ax_q),
    .prod (sq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      out_negx <= nx_d[1];
      out_x2   <= sq[WORK_FRAC+WORD_W-1:WORK_FRAC];
      out_term <= ax_d[1];
      out_sum  <= (n_terms != '0) ? $signed(ax_d[1]) : '0;
    end
  end

  always_comb begin
    lane.valid = out_vld;
    lane.neg_x = out_negx;
    lane.x2    = out_x2;
    lane.term  = out_term;
    lane.sum   = out_sum;
  end

endmodule

### hdl/tse_term.sv
// One series term: the previous term times x squared, divided by (2i)(2i+1) via a
// constant reciprocal with a one-step correction, then summed; odd i is subtracted.
// Depends on tse_pkg and tse_wide_mul.
module tse_term #(
  parameter int IDX = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [tse_pkg::TERM_N_W-1:0] n_terms,
  input  tse_pkg::tse_lane_t           lane_in,
  output tse_pkg::tse_lane_t           lane_out
);
  import tse_pkg::*;

  localparam int SIDE_DEPTH = 6;
  localparam logic [DIV_W-1:0]  DIV     = DIV_W'((2 * IDX) * (2 * IDX + 1));
  localparam logic [WORD_W:0]   ONE_SHL = {1'b1, {WORD_W{1'b0}}};
  localparam logic [WORD_W-1:0] RECIP   = WORD_W'(ONE_SHL / {{(WORD_W+1-DIV_W){1'b0}}, DIV});
  localparam bit SUBTRACT = (IDX % 2) == 1;

  logic [PROD_W-1:0]        prod1;
  logic [PROD_W-1:0]        prod2;
  logic [WORD_W-1:0]        p;
  logic [WORD_W-1:0]        qe_now;
  logic [WORD_W-1:0]        p_a;
  logic [WORD_W-1:0]        p_b;
  logic [WORD_W-1:0]        p_c;
  logic [WORD_W-1:0]        qe_c;
  logic [WORD_W-1:0]        qd_c;
  logic [WORD_W-1:0]        term_c;
  logic [WORD_W-1:0]        rem_c;
  logic                     active;

  logic [SIDE_DEPTH-1:0]    sv;
  logic [SIDE_DEPTH-1:0]    sd_negx;
  logic [WORD_W-1:0]        sd_x2  [SIDE_DEPTH];
  logic signed [WORD_W-1:0] sd_sum [SIDE_DEPTH];

  logic                     out_vld;
  logic                     out_negx;
  logic [WORD_W-1:0]        out_x2;
  logic [WORD_W-1:0]        out_term;
  logic signed [WORD_W-1:0] out_sum;

  tse_wide_mul u_mul_x2 (
    .clk  (clk),
    .en   (en),
    .a    (lane_in.term),
    .b    (lane_in.x2),
    .prod (prod1)
  );

  assign p = prod1[WORK_FRAC+WORD_W-1:WORK_FRAC];

  tse_wide_mul u_mul_rcp (
    .clk  (clk),
    .en   (en),
    .a    (p),
    .b    (RECIP),
    .prod (prod2)
  );

  assign qe_now = prod2[PROD_W-1:WORD_W];
  assign rem_c  = p_c - qd_c;
  assign active = TERM_N_W'(IDX) < n_terms;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv      <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      sv      <= {sv[SIDE_DEPTH-2:0], lane_in.valid};
      out_vld <= sv[SIDE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_negx   <= {sd_negx[SIDE_DEPTH-2:0], lane_in.neg_x};
      sd_x2[0]  <= lane_in.x2;
      sd_sum[0] <= lane_in.sum;
      for (int k = 1; k < SIDE_DEPTH; k++) begin
        sd_x2[k]  <= sd_x2[k-1];
        sd_sum[k] <= sd_sum[k-1];
      end
      p_a  <= p;
      p_b  <= p_a;
      p_c  <= p_b;
      qe_c <= qe_now;
      qd_c <= WORD_W'(qe_now * DIV);
      // The reciprocal estimate is at most one below the true quotient.
      term_c <= (rem_c >= {{(WORD_W-DIV_W){1'b0}}, DIV}) ? qe_c + 1'b1 : qe_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_negx <= sd_negx[SIDE_DEPTH-1];
      out_x2   <= sd_x2[SIDE_DEPTH-1];
      out_term <= term_c;
      if (!active) begin
        out_sum <= sd_sum[SIDE_DEPTH-1];
      end else if (SUBTRACT) begin
        out_sum <= sd_sum[SIDE_DEPTH-1] - $signed(term_c);
      end else begin
        out_sum <= sd_sum[SIDE_DEPTH-1] + $signed(term_c);
      end
    end
  end

  always_comb begin
    lane_out.valid = out_vld;
    lane_out.neg_x = out_negx;
    lane_out.x2    = out_x2;
    lane_out.term  = out_term;
    lane_out.sum   = out_sum;
  end

endmodule

### hdl/taylor_sine_evaluator.sv
// Channel     | Dir | Beat contents
// angle       | in  | angle, signed Q8.24 radians
// sine        | out | sine_value, signed Q3.29
// APB         | in  | term_count at byte address 0
// One beat is taken every cycle while the sine side does not stall. A beat passes the reduction,
// a stage for each series term after the first, and the negate and saturate output registers.
// The whole pipeline advances together whenever the output register is empty or being taken,
// so a stall on the sine side holds every stage and nothing is lost or repeated.
// Reset is synchronous and clears the valid bits and sets term_count to 10.
module taylor_sine_evaluator #(
  parameter int MAX_TERMS       = tse_pkg::DEF_MAX_TERMS,
  parameter int ANGLE_FRAC_BITS = tse_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  tse_angle_if.sink                        angle,
  tse_sine_if.source                       sine,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tse_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tse_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tse_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import tse_pkg::*;

  localparam logic signed [WORD_W-1:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [WORD_W-1:0] SAT_LO = -64'sd2147483648;

  logic [TERM_COUNT_W-1:0]  term_count;
  logic [TERM_N_W-1:0]      n_terms;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     en;
  tse_lane_t                lanes [MAX_TERMS];
  tse_lane_t                last;

  logic                     neg_vld;
  logic signed [WORD_W-1:0] neg_sum;
  logic signed [WORD_W-1:0] shifted;
  logic signed [SINE_W-1:0] sat_next;
  logic                     sine_vld;
  logic signed [SINE_W-1:0] sine_data;

  assign reg_idx = paddr[APB_ADDR_W-1:REG_IDX_LSB];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_TERM_COUNT) ? APB_DATA_W'(term_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= TERM_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_TERM_COUNT)) begin
      term_count <= pwdata[TERM_COUNT_W-1:0];
    end
  end

  assign n_terms = (term_count > MAX_TERMS) ? TERM_N_W'(MAX_TERMS) : TERM_N_W'(term_count);

  assign en          = !sine_vld || sine.ready;
  assign angle.ready = en;

  tse_reduce #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (angle.valid),
    .angle    (angle.angle),
    .n_terms  (n_terms),
    .lane     (lanes[0])
  );

  for (genvar i = 1; i < MAX_TERMS; i++) begin : g_term
    tse_term #(
      .IDX (i)
    ) u_term (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .n_terms  (n_terms),
      .lane_in  (lanes[i-1]),
      .lane_out (lanes[i])
    );
  end

  assign last = lanes[MAX_TERMS-1];

  // Arithmetic right shift floors the Q56 sum to Q3.29.
  assign shifted = neg_sum >>> (WORK_FRAC - OUT_FRAC);

  always_comb begin
    if (shifted > SAT_HI) begin
      sat_next = SAT_HI[SINE_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat_next = SAT_LO[SINE_W-1:0];
    end else begin
      sat_next = shifted[SINE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neg_vld  <= 1'b0;
      sine_vld <= 1'b0;
    end else if (en) begin
      neg_vld  <= last.valid;
      sine_vld <= neg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_sum   <= last.neg_x ? -last.sum : last.sum;
      sine_data <= sat_next;
    end
  end

  assign sine.valid      = sine_vld;
  assign sine.sine_value = sine_data;

endmodule

### hdl/tse_checker.sv
// Port-level checks for the Taylor series sine evaluator, bound to the top level.
// Depends on tse_pkg for widths, the result bound and the register code.
module tse_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [tse_pkg::SINE_W-1:0]       out_data,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic                             pready,
  input logic [tse_pkg::APB_ADDR_W-1:0]   paddr,
  input logic [tse_pkg::APB_DATA_W-1:0]   pwdata,
  input logic [tse_pkg::APB_DATA_W-1:0]   prdata
);
  import tse_pkg::*;

  logic cfg_wr;
  logic idx_tc;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign idx_tc = paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_TERM_COUNT;

  // Reset empties the output register.
  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid after reset");

  // A waiting result beat holds its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // With the output register empty the pipeline must take a new angle.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready while output is empty");

  // A write to term_count reads back in the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && idx_tc) ##1 idx_tc |->
      prdata == APB_DATA_W'($past(pwdata[TERM_COUNT_W-1:0])))
    else $error("term_count readback mismatch");

  // Every result beat stays within about pi in magnitude.
  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_data) <= SINE_BOUND) && ($signed(out_data) >= -SINE_BOUND))
    else $error("sine result out of range");

endmodule

bind taylor_sine_evaluator tse_checker u_tse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (angle.ready),
  .out_valid (sine.valid),
  .out_ready (sine.ready),
  .out_data  (sine.sine_value),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for taylor_sine_evaluator: a directed table, then random angles.
// Results are checked against a local fixed-point series predictor under several term counts.
// Depends on tse_pkg, tse_angle_if and tse_sine_if.
module testbench;
  import tse_pkg::*;

  typedef enum logic [0:0] {
    ROW_ANGLE,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [APB_ADDR_W-1:0] addr;
    logic [APB_DATA_W-1:0] data;
    logic                  has_sine;
    logic [SINE_W-1:0]     sine;
  } stim_row_t;

  localparam logic [APB_ADDR_W-1:0] ADDR_TERM_COUNT = APB_ADDR_W'(REG_TERM_COUNT) << REG_IDX_LSB;
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED     =
    APB_ADDR_W'(ADDR_TERM_COUNT + (1 << REG_IDX_LSB));

  localparam logic [ANGLE_W-1:0] PI_ANGLE      = 32'h03243F6A;
  localparam logic [ANGLE_W-1:0] HALF_PI_ANGLE = 32'h01921FB5;
  localparam logic [ANGLE_W-1:0] TWO_PI_ANGLE  = 32'h06487ED5;

  localparam logic signed [WORD_W-1:0] SINE_MAX = 64'sd2147483647;
  localparam logic signed [WORD_W-1:0] SINE_MIN = -64'sd2147483648;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_ITEMS  = 100;
  localparam int PHASES       = 8;
  localparam int ROWS         = 24;

  localparam stim_row_t DIRECTED_ROWS [ROWS] = '{
    '{ROW_ANGLE, ADDR_TERM_COUNT, 32'h00000000,                1'b1, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, 32'h00000001,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, 32'hFFFFFFFF,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, 32'h7FFFFFFF,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, 32'h80000000,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, PI_ANGLE,                    1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, -PI_ANGLE,                   1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, PI_ANGLE + 1,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, HALF_PI_ANGLE,               1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, -HALF_PI_ANGLE,              1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, TWO_PI_ANGLE,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, -TWO_PI_ANGLE,               1'b0, 32'h00000000},
    '{ROW_REG,   ADDR_TERM_COUNT, 32'hFFFFFFF0,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, HALF_PI_ANGLE,               1'b1, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, 32'h80000000,                1'b1, 32'h00000000},
    '{ROW_REG,   ADDR_TERM_COUNT, 32'h0000000F,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, 32'h7FFFFFFF,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, HALF_PI_ANGLE,               1'b0, 32'h00000000},
    '{ROW_REG,   ADDR_TERM_COUNT, 32'h00000001,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, HALF_PI_ANGLE,               1'b0, 32'h00000000},
    '{ROW_REG,   ADDR_UNUSED,     32'h00000000,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, -HALF_PI_ANGLE,              1'b0, 32'h00000000},
    '{ROW_REG,   ADDR_TERM_COUNT, 32'h0000000C,                1'b0, 32'h00000000},
    '{ROW_ANGLE, ADDR_TERM_COUNT, PI_ANGLE,                    1'b0, 32'h00000000}
  };

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic sink_ready = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   mismatch_count = 0;
  bit   src_calm = 1'b0;
  bit   snk_calm = 1'b0;
  logic [TERM_COUNT_W-1:0] term_count_now;
  logic [SINE_W-1:0] sine_due_q [$];

  tse_angle_if angle_ch ();
  tse_sine_if  sine_ch ();

  assign sine_ch.ready = sink_ready;

  taylor_sine_evaluator u_dut (
    .clk     (clk),
    .rst     (rst),
    .angle   (angle_ch),
    .sine    (sine_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  function automatic logic [WORD_W-1:0] mul_q56(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [PROD_W-1:0] p;
    p = a * b;
    return p[WORK_FRAC+WORD_W-1:WORK_FRAC];
  endfunction

  function automatic logic [SINE_W-1:0] predict_sine(input logic [ANGLE_W-1:0] raw,
                                                     input logic [TERM_COUNT_W-1:0] tc);
    logic [WORD_W-1:0] mag;
    logic [WORD_W-1:0] modulus;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] ax;
    logic [WORD_W-1:0] x2;
    logic [WORD_W-1:0] term;
    logic [WORD_W-1:0] divisor;
    logic signed [WORD_W-1:0] acc;
    logic signed [WORD_W-1:0] q;
    logic neg_angle;
    logic neg_x;
    int n;
    int i;
    neg_angle = raw[ANGLE_W-1];
    mag = neg_angle ? (64'd1 << ANGLE_W) - {32'd0, raw} : {32'd0, raw};
    modulus = TWO_PI_Q60 >> (28 - DEF_ANGLE_FRAC_BITS);
    rem = (mag << 32) % modulus;
    if (neg_angle && rem != 0) begin
      rem = modulus - rem;
    end
    rem = rem >> (DEF_ANGLE_FRAC_BITS + 32 - WORK_FRAC);
    if (rem >= PI_Q56) begin
      neg_x = 1'b1;
      ax = (rem < TWO_PI_Q56) ? TWO_PI_Q56 - rem : '0;
    end else begin
      neg_x = 1'b0;
      ax = rem;
    end
    n = (tc > DEF_MAX_TERMS) ? DEF_MAX_TERMS : int'(tc);
    x2 = mul_q56(ax, ax);
    term = ax;
    acc = '0;
    for (i = 0; i < n; i++) begin
      if (i > 0) begin
        divisor = WORD_W'((2 * i) * (2 * i + 1));
        term = mul_q56(term, x2) / divisor;
      end
      if (i % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (neg_x) begin
      acc = -acc;
    end
    q = acc >>> (WORK_FRAC - OUT_FRAC);
    if (q > SINE_MAX) begin
      q = SINE_MAX;
    end
    if (q < SINE_MIN) begin
      q = SINE_MIN;
    end
    return q[SINE_W-1:0];
  endfunction

  function automatic int pick_pause();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    int k;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        k = $urandom_range(0, 40);
        k = k - 20;
        return ANGLE_W'(k * int'(PI_ANGLE) + int'($urandom_range(0, 511)) - 256);
      end
      2: return ANGLE_W'(int'($urandom_range(0, 2 * TWO_PI_ANGLE)) - int'(TWO_PI_ANGLE));
      default: return ANGLE_W'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch, %s: expected %h, got %h", what, want, got);
    end
  endtask

  task automatic send_angle(input logic [ANGLE_W-1:0] value, input logic has_sine,
                            input logic [SINE_W-1:0] sine);
    int gap;
    angle_ch.valid <= 1'b1;
    angle_ch.angle <= value;
    do @(posedge clk); while (!angle_ch.ready);
    sine_due_q.push_back(has_sine ? sine : predict_sine(value, term_count_now));
    gap = (!src_calm && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
    if (gap != 0) begin
      angle_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] data);
    logic readback;
    angle_ch.valid <= 1'b0;
    while (sine_due_q.size() != 0) @(posedge clk);
    readback = (addr[APB_ADDR_W-1:REG_IDX_LSB] == REG_TERM_COUNT);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (readback) begin
      term_count_now = data[TERM_COUNT_W-1:0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== APB_DATA_W'(term_count_now)) begin
        note_mismatch("term_count readback", APB_DATA_W'(term_count_now), prdata);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && sine_ch.valid && sine_ch.ready) begin
      if (sine_due_q.size() == 0) begin
        note_mismatch("sine beat with nothing pending", '0, sine_ch.sine_value);
      end else begin
        if (sine_ch.sine_value !== sine_due_q[0]) begin
          note_mismatch("sine_value", sine_due_q[0], sine_ch.sine_value);
        end
        void'(sine_due_q.pop_front());
      end
    end
    if (hold_left != 0) begin
      sink_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!snk_calm && $urandom_range(0, 3) == 0) begin
      sink_ready <= 1'b0;
      hold_left <= pick_pause() - 1;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  initial begin
    int phase;
    int item;
    logic [TERM_COUNT_W-1:0] tc;
    rst            <= 1'b1;
    angle_ch.valid <= 1'b0;
    angle_ch.angle <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    term_count_now = TERM_COUNT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_REG) begin
        write_register(DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].data);
      end else begin
        send_angle(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].has_sine, DIRECTED_ROWS[r].sine);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: tc = 4'd12;
        1: tc = 4'd1;
        2: tc = 4'd0;
        3: tc = 4'd15;
        default: tc = TERM_COUNT_W'($urandom_range(0, 15));
      endcase
      if ($urandom_range(0, 1) == 1) begin
        write_register(ADDR_UNUSED, $urandom);
      end
      write_register(ADDR_TERM_COUNT, ($urandom & ~32'hF) | APB_DATA_W'(tc));
      src_calm = (phase % 3 == 1);
      snk_calm = (phase % 4 == 2);
      for (item = 0; item < PHASE_ITEMS; item++) begin
        send_angle(pick_angle(), 1'b0, '0);
      end
    end

    angle_ch.valid <= 1'b0;
    snk_calm = 1'b0;
    while (sine_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
